// File: hdl/tgs_pkg.sv
// Shared types, codes and widths of the tile grid store.
package tgs_pkg;

  // Fixed field widths.
  localparam int CMD_W      = 3;
  localparam int TYPE_W     = 4;
  localparam int GRID_W     = 7;
  localparam int BLK_W      = 8;
  localparam int CRD_W      = 18;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_USED_W = 37;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SLOT_W     = 4;

  // Default grid capacity.
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = 17;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEIGH     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_IDX = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_POS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL      = 3'd4;

  // Cell type codes used by the logic.
  localparam logic [TYPE_W-1:0] TYPE_NONE  = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_SOLID = 4'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd3;

  // Register reset values.
  localparam logic [GRID_W-1:0] GRID_COLUMNS_RST = 7'd64;
  localparam logic [GRID_W-1:0] GRID_ROWS_RST    = 7'd64;
  localparam logic [BLK_W-1:0]  BLOCK_WIDTH_RST  = 8'd16;
  localparam logic [BLK_W-1:0]  BLOCK_HEIGHT_RST = 8'd16;

  // Read slots: slot 0 is the addressed cell, the neighbours follow.
  localparam logic [SLOT_W-1:0] SLOT_CENTER = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST   = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              clear;
    logic              take;
    logic              rd_issue;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_idx;
    logic              div_start;
    logic              div_second;
    logic              wr_pos;
    logic              fill_setup;
    logic              fill_step;
    logic              load_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic region_ok;
    logic fill_last;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/tgs_div.sv
// Sequential signed divider by a block size, truncating toward zero.
module tgs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tgs_pkg::CRD_W-1:0]  dividend,
  input  logic        [tgs_pkg::BLK_W-1:0]  divisor,
  output logic signed [tgs_pkg::CRD_W-1:0]  quotient,
  output logic                              done
);
  import tgs_pkg::*;

  localparam int MAG_W = CRD_W - 1;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              running;
  logic [CNT_W-1:0]  step;
  logic              neg;
  logic [BLK_W-1:0]  rem;
  logic [BLK_W-1:0]  dvs;
  logic [MAG_W-1:0]  quo;
  logic [CRD_W-1:0]  mag;
  logic [BLK_W:0]    trial;
  logic              ge;
  logic [CRD_W-1:0]  quo_ext;

  // Magnitude of the dividend; the sign is applied again at the end.
  assign mag     = dividend[CRD_W-1] ? CRD_W'(-dividend) : CRD_W'(dividend);
  assign trial   = {rem, quo[MAG_W-1]};
  assign ge      = trial >= {1'b0, dvs};
  assign quo_ext = {1'b0, quo};
  assign quotient = neg ? -quo_ext : quo_ext;

  // Step counter and handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (step == CNT_W'(DIV_STEPS - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[CRD_W-1];
      quo <= mag[MAG_W-1:0];
      rem <= '0;
      dvs <= (divisor == '0) ? BLK_W'(1) : divisor;
    end else if (running) begin
      rem <= ge ? BLK_W'(trial - {1'b0, dvs}) : trial[BLK_W-1:0];
      quo <= {quo[MAG_W-2:0], ge};
    end
  end

endmodule

// File: hdl/tgs_datapath.sv
// Datapath: registers, cell memory, address logic, dividers and result buffer.
module tgs_datapath #(
  parameter int MAX_COLUMNS = tgs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tgs_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tgs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  tgs_pkg::ctl_t                       ctl,
  output tgs_pkg::stat_t                      stat,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tgs_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import tgs_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Cell address: column-major, MAX_ROWS cells per column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [GRID_W-1:0] c,
                                                  input logic [GRID_W-1:0] r);
    return ADDR_W'(32'(c) * MAX_ROWS + 32'(r));
  endfunction

  function automatic logic in_grid(input logic signed [CRD_W-1:0] c,
                                   input logic signed [CRD_W-1:0] r,
                                   input logic signed [CRD_W-1:0] nc,
                                   input logic signed [CRD_W-1:0] nr);
    return (c >= 0) && (r >= 0) && (c < nc) && (r < nr);
  endfunction

  // Column offset of a read slot.
  function automatic logic signed [1:0] slot_dc(input logic [SLOT_W-1:0] k);
    logic signed [1:0] d;
    d = 2'sd0;
    if (k inside {4'd1, 4'd4, 4'd6}) d = -2'sd1;
    if (k inside {4'd3, 4'd5, 4'd8}) d = 2'sd1;
    return d;
  endfunction

  // Row offset of a read slot.
  function automatic logic signed [1:0] slot_dr(input logic [SLOT_W-1:0] k);
    logic signed [1:0] d;
    d = 2'sd0;
    if (k inside {4'd1, 4'd2, 4'd3}) d = -2'sd1;
    if (k inside {4'd6, 4'd7, 4'd8}) d = 2'sd1;
    return d;
  endfunction

  // Configuration registers.
  logic [GRID_W-1:0] grid_columns;
  logic [GRID_W-1:0] grid_rows;
  logic [BLK_W-1:0]  block_width_px;
  logic [BLK_W-1:0]  block_height_px;

  // Grid size in use.
  logic [GRID_W-1:0]       ncols_eff;
  logic [GRID_W-1:0]       nrows_eff;
  logic signed [CRD_W-1:0] ncols_s;
  logic signed [CRD_W-1:0] nrows_s;

  // Current item.
  logic signed [15:0]  it_col;
  logic signed [15:0]  it_row;
  logic [TYPE_W-1:0]   it_type;
  logic signed [15:0]  it_px;
  logic signed [15:0]  it_py;
  logic [14:0]         it_sx;
  logic [14:0]         it_sy;

  // Dividers.
  logic signed [CRD_W-1:0] div_x_in;
  logic signed [CRD_W-1:0] div_y_in;
  logic signed [CRD_W-1:0] qx;
  logic signed [CRD_W-1:0] qy;
  logic                    done_x;
  logic                    done_y;
  logic signed [CRD_W-1:0] c1_q;
  logic signed [CRD_W-1:0] r1_q;

  // Area walk.
  logic [GRID_W-1:0] fill_col;
  logic [GRID_W-1:0] fill_row;
  logic [GRID_W-1:0] fill_row_lo;
  logic [GRID_W-1:0] fill_col_hi;
  logic [GRID_W-1:0] fill_row_hi;
  logic [GRID_W-1:0] c1_clip;
  logic [GRID_W-1:0] r1_clip;
  logic [GRID_W-1:0] c2_clip;
  logic [GRID_W-1:0] r2_clip;

  // Memory and its ports.
  logic [TYPE_W-1:0]       mem [DEPTH];
  logic [ADDR_W-1:0]       clear_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [TYPE_W-1:0]       wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic [TYPE_W-1:0]       rd_data;
  logic signed [CRD_W-1:0] rd_c;
  logic signed [CRD_W-1:0] rd_r;
  logic                    rd_ok;
  logic                    rd_pend;
  logic [SLOT_W-1:0]       rd_slot;
  logic                    rd_in;
  logic signed [CRD_W-1:0] pt_c;
  logic signed [CRD_W-1:0] pt_r;
  logic                    pt_ok;

  // Result being built and the output register.
  logic [TYPE_W-1:0]     res_cell;
  logic                  res_in_range;
  logic [TYPE_W-1:0]     res_nb [8];
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns    <= GRID_COLUMNS_RST;
      grid_rows       <= GRID_ROWS_RST;
      block_width_px  <= BLOCK_WIDTH_RST;
      block_height_px <= BLOCK_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_COLUMNS: grid_columns    <= cfg_data[GRID_W-1:0];
        CFG_GRID_ROWS:    grid_rows       <= cfg_data[GRID_W-1:0];
        CFG_BLOCK_WIDTH:  block_width_px  <= cfg_data[BLK_W-1:0];
        CFG_BLOCK_HEIGHT: block_height_px <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // A grid size above the capacity acts as the capacity.
  assign ncols_eff = (32'(grid_columns) > MAX_COLUMNS) ? GRID_W'(MAX_COLUMNS) : grid_columns;
  assign nrows_eff = (32'(grid_rows) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : grid_rows;
  assign ncols_s   = CRD_W'(ncols_eff);
  assign nrows_s   = CRD_W'(nrows_eff);

  // Item capture; tdata fields from bit 0: column, row, type, x, y, width, height.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      it_col  <= s_axis_tdata[15:0];
      it_row  <= s_axis_tdata[31:16];
      it_type <= s_axis_tdata[35:32];
      it_px   <= s_axis_tdata[51:36];
      it_py   <= s_axis_tdata[67:52];
      it_sx   <= s_axis_tdata[82:68];
      it_sy   <= s_axis_tdata[97:83];
    end
  end

  // Divider operands: first corner, or far corner of the rectangle.
  assign div_x_in = ctl.div_second ? CRD_W'(it_px) + $signed({3'b000, it_sx})
                                   : CRD_W'(it_px);
  assign div_y_in = ctl.div_second ? CRD_W'(it_py) + $signed({3'b000, it_sy})
                                   : CRD_W'(it_py);

  tgs_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_x_in),
    .divisor  (block_width_px),
    .quotient (qx),
    .done     (done_x)
  );

  tgs_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_y_in),
    .divisor  (block_height_px),
    .quotient (qy),
    .done     (done_y)
  );

  // Keep the first corner while the far corner is divided.
  always_ff @(posedge clk) begin
    if (ctl.div_start && ctl.div_second) begin
      c1_q <= qx;
      r1_q <= qy;
    end
  end

  // Clipping of the rectangle to the grid.
  assign c1_clip = (c1_q < 0) ? '0 : c1_q[GRID_W-1:0];
  assign r1_clip = (r1_q < 0) ? '0 : r1_q[GRID_W-1:0];
  assign c2_clip = (qx >= ncols_s) ? GRID_W'(ncols_eff - 1'b1) : qx[GRID_W-1:0];
  assign r2_clip = (qy >= nrows_s) ? GRID_W'(nrows_eff - 1'b1) : qy[GRID_W-1:0];

  assign stat.region_ok = (ncols_eff != '0) && (nrows_eff != '0) && (qx >= 0) && (qy >= 0)
                          && (c1_q < ncols_s) && (r1_q < nrows_s);

  // Area walk, rows inside columns.
  always_ff @(posedge clk) begin
    if (ctl.fill_setup) begin
      fill_col    <= c1_clip;
      fill_row    <= r1_clip;
      fill_row_lo <= r1_clip;
      fill_col_hi <= c2_clip;
      fill_row_hi <= r2_clip;
    end else if (ctl.fill_step) begin
      if (fill_row == fill_row_hi) begin
        fill_row <= fill_row_lo;
        fill_col <= fill_col + 1'b1;
      end else begin
        fill_row <= fill_row + 1'b1;
      end
    end
  end

  assign stat.fill_last = (fill_col == fill_col_hi) && (fill_row == fill_row_hi);

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (ctl.clear) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign stat.clear_last = (clear_addr == ADDR_W'(DEPTH - 1));

  // Point write coordinates: cell index or divided pixel position.
  assign pt_c  = ctl.wr_pos ? qx : CRD_W'(it_col);
  assign pt_r  = ctl.wr_pos ? qy : CRD_W'(it_row);
  assign pt_ok = in_grid(pt_c, pt_r, ncols_s, nrows_s);

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr(pt_c[GRID_W-1:0], pt_r[GRID_W-1:0]);
    wr_data = it_type;
    if (ctl.clear) begin
      wr_en   = 1'b1;
      wr_addr = clear_addr;
      wr_data = TYPE_SOLID;
    end else if (ctl.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(fill_col, fill_row);
    end else if (ctl.wr_idx || ctl.wr_pos) begin
      wr_en = pt_ok;
    end
  end

  // Read address of the current slot.
  assign rd_c    = CRD_W'(it_col) + CRD_W'(slot_dc(ctl.rd_slot));
  assign rd_r    = CRD_W'(it_row) + CRD_W'(slot_dr(ctl.rd_slot));
  assign rd_ok   = in_grid(rd_c, rd_r, ncols_s, nrows_s);
  assign rd_addr = cell_addr(rd_c[GRID_W-1:0], rd_r[GRID_W-1:0]);

  // Cell memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Read tracking: the data arrives in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ctl.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_slot <= ctl.rd_slot;
      rd_in   <= rd_ok;
    end
  end

  // Result fields.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res_cell     <= TYPE_NONE;
      res_in_range <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        res_nb[i] <= TYPE_NONE;
      end
    end else begin
      if (rd_pend) begin
        if (rd_slot == SLOT_CENTER) begin
          res_cell <= rd_in ? rd_data : TYPE_NONE;
        end else begin
          res_nb[3'(rd_slot - 1'b1)] <= rd_in ? rd_data : TYPE_NONE;
        end
      end
      if (ctl.rd_issue && (ctl.rd_slot == SLOT_CENTER)) begin
        res_in_range <= rd_ok;
      end
      if (ctl.wr_idx || ctl.wr_pos) begin
        res_in_range <= pt_ok;
      end
      if (ctl.fill_setup) begin
        res_in_range <= stat.region_ok;
      end
    end
  end

  assign stat.div_done = done_x && done_y;

  // Output register.
  assign stat.out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data <= {(OUT_DATA_W - OUT_USED_W)'(0), res_nb[7], res_nb[6], res_nb[5], res_nb[4],
                   res_nb[3], res_nb[2], res_nb[1], res_nb[0], res_in_range, res_cell};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: hdl/tgs_ctrl.sv
// Controller: sequences the clearing pass and each command over the datapath.
module tgs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tgs_pkg::CMD_W-1:0]   s_axis_tuser,
  input  tgs_pkg::stat_t              stat,
  output tgs_pkg::ctl_t               ctl
);
  import tgs_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR      = 13'b0000000000001,
    S_IDLE       = 13'b0000000000010,
    S_READ       = 13'b0000000000100,
    S_READ_WAIT  = 13'b0000000001000,
    S_WRITE      = 13'b0000000010000,
    S_DIV1       = 13'b0000000100000,
    S_DIV1_WAIT  = 13'b0000001000000,
    S_WRITE_POS  = 13'b0000010000000,
    S_DIV2       = 13'b0000100000000,
    S_DIV2_WAIT  = 13'b0001000000000,
    S_FILL_SETUP = 13'b0010000000000,
    S_FILL       = 13'b0100000000000,
    S_RESULT     = 13'b1000000000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] rd_cnt;
  logic [SLOT_W-1:0] rd_cnt_next;
  logic              is_nb;
  logic              is_nb_next;
  logic              is_fill;
  logic              is_fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_cnt  <= '0;
      is_nb   <= 1'b0;
      is_fill <= 1'b0;
    end else begin
      state   <= state_next;
      rd_cnt  <= rd_cnt_next;
      is_nb   <= is_nb_next;
      is_fill <= is_fill_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    rd_cnt_next  = rd_cnt;
    is_nb_next   = is_nb;
    is_fill_next = is_fill;
    ctl          = '0;
    ctl.rd_slot  = rd_cnt;
    case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ctl.take     = 1'b1;
          rd_cnt_next  = '0;
          is_nb_next   = (s_axis_tuser == CMD_NEIGH);
          is_fill_next = (s_axis_tuser == CMD_FILL);
          case (s_axis_tuser)
            CMD_READ, CMD_NEIGH:     state_next = S_READ;
            CMD_WRITE_IDX:           state_next = S_WRITE;
            CMD_WRITE_POS, CMD_FILL: state_next = S_DIV1;
            default:                 state_next = S_RESULT;
          endcase
        end
      end
      S_READ: begin
        ctl.rd_issue = 1'b1;
        if (rd_cnt == (is_nb ? SLOT_LAST : SLOT_CENTER)) begin
          state_next = S_READ_WAIT;
        end else begin
          rd_cnt_next = rd_cnt + 1'b1;
        end
      end
      S_READ_WAIT: begin
        state_next = S_RESULT;
      end
      S_WRITE: begin
        ctl.wr_idx = 1'b1;
        state_next = S_RESULT;
      end
      S_DIV1: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (stat.div_done) begin
          state_next = is_fill ? S_DIV2 : S_WRITE_POS;
        end
      end
      S_WRITE_POS: begin
        ctl.wr_pos = 1'b1;
        state_next = S_RESULT;
      end
      S_DIV2: begin
        ctl.div_start  = 1'b1;
        ctl.div_second = 1'b1;
        state_next     = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (stat.div_done) begin
          state_next = S_FILL_SETUP;
        end
      end
      S_FILL_SETUP: begin
        ctl.fill_setup = 1'b1;
        state_next     = stat.region_ok ? S_FILL : S_RESULT;
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/tile_grid_store_with_neighbours_unit.sv
// Top level of the tile grid store with neighbour read.
//
// Commands arrive as beats on the s_axis channel (command code in tuser, operands
// in tdata); every command returns exactly one beat on the m_axis channel.
// The cfg channel writes the grid size and block size registers; cfg_ready is
// always high and writes are expected only while no command is in flight.
// The pixel-to-cell divisions run in two 17-step dividers (x and y in parallel),
// the cell memory has one read and one write port, and commands are handled
// one at a time: a new input beat is accepted only after the result of the
// previous command has been loaded into the output register.
// After reset a clearing pass writes every cell solid, one cell per cycle;
// s_axis_tready stays low until it ends.
// A finished result waits in the output register while the next command is
// accepted and executed; a further result is held back until m_axis_tready.
module tile_grid_store_with_neighbours_unit #(
  parameter int MAX_COLUMNS = tgs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tgs_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Command beats.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cell_column[15:0], cell_row[31:16], new_type[35:32], pos_x[51:36],
  // pos_y[67:52], size_x[82:68], size_y[97:83], zero[103:98]
  input  logic [tgs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd[2:0]
  input  logic [tgs_pkg::CMD_W-1:0]        s_axis_tuser,
  // Result beats.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_type[3:0], in_range[4], nb_top_left[8:5], nb_top[12:9],
  // nb_top_right[16:13], nb_left[20:17], nb_right[24:21],
  // nb_bottom_left[28:25], nb_bottom[32:29], nb_bottom_right[36:33], zero[39:37]
  output logic [tgs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Register writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tgs_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tgs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat          (stat),
    .ctl           (ctl)
  );

  tgs_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .ctl           (ctl),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/tgs_checker.sv
// Port-level checks of the tile grid store, bound to the top level.
module tgs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tgs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tgs_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("command accepted during clearing pass");

  // Commands are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

  // A cell outside the grid never reports a type, and padding stays zero.
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
                      && (m_axis_tdata[4] || (m_axis_tdata[3:0] == TYPE_NONE)))
    else $error("malformed result beat");

endmodule

bind tile_grid_store_with_neighbours_unit tgs_checker u_tgs_checker (.*);

// File: tb/sv/tile_grid_store_with_neighbours_unit_test.sv
// Self-checking testbench for the tile grid store with neighbour read.
`timescale 1ns / 100ps

module tile_grid_store_with_neighbours_unit_test;
  import tgs_pkg::*;

  localparam int NCOL           = DEF_MAX_COLUMNS;
  localparam int NROW           = DEF_MAX_ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_LIMIT   = 10;

  // One command beat without its command code, first field in the lowest bits.
  typedef struct packed {
    logic [14:0] size_y;
    logic [14:0] size_x;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [3:0]  new_type;
    logic [15:0] cell_row;
    logic [15:0] cell_column;
  } tile_cmd_t;

  // One result beat; nb[0] is the up-left neighbour, nb[7] the down-right one.
  typedef struct packed {
    logic [7:0][TYPE_W-1:0] nb;
    logic                   in_range;
    logic [TYPE_W-1:0]      cell_type;
  } tile_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the cell store and of the registers.
  logic [TYPE_W-1:0] tile_model [NCOL][NROW];
  logic [GRID_W-1:0] grid_cols_q;
  logic [GRID_W-1:0] grid_rows_q;
  logic [BLK_W-1:0]  blk_w_q;
  logic [BLK_W-1:0]  blk_h_q;

  tile_result_t pending_results [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int settings_count  = 0;
  int quiet_cycles    = 0;

  string nb_names [8] = '{"nb_top_left", "nb_top", "nb_top_right", "nb_left",
                          "nb_right", "nb_bottom_left", "nb_bottom", "nb_bottom_right"};

  tile_grid_store_with_neighbours_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Grid size in use, with oversized settings clamped to the store.
  function automatic int cols_active();
    return (grid_cols_q > NCOL) ? NCOL : int'(grid_cols_q);
  endfunction

  function automatic int rows_active();
    return (grid_rows_q > NROW) ? NROW : int'(grid_rows_q);
  endfunction

  function automatic bit on_grid(int col, int row);
    return col >= 0 && row >= 0 && col < cols_active() && row < rows_active();
  endfunction

  function automatic logic [TYPE_W-1:0] cell_at(int col, int row);
    return on_grid(col, row) ? tile_model[col][row] : TYPE_NONE;
  endfunction

  function automatic bit store_cell(int col, int row, logic [TYPE_W-1:0] kind);
    if (!on_grid(col, row))
      return 1'b0;
    tile_model[col][row] = kind;
    return 1'b1;
  endfunction

  // Pixel to cell, truncating toward zero; a zero block size acts as one.
  function automatic int px_to_cell(int p, logic [BLK_W-1:0] size_px);
    int d;
    d = (size_px == 0) ? 1 : int'(size_px);
    return p / d;
  endfunction

  // Works out the result of one command and applies its writes to the shadow store.
  function automatic tile_result_t predict_tile_result(logic [CMD_W-1:0] cmd, tile_cmd_t it);
    tile_result_t res;
    int col, row, px, py, c1, c2, r1, r2, ncol, nrow, k;
    bit any;
    col = int'($signed(it.cell_column));
    row = int'($signed(it.cell_row));
    px  = int'($signed(it.pos_x));
    py  = int'($signed(it.pos_y));
    res = '0;
    case (cmd)
      CMD_READ: begin
        res.cell_type = cell_at(col, row);
        res.in_range  = on_grid(col, row);
      end
      CMD_NEIGH: begin
        res.cell_type = cell_at(col, row);
        res.in_range  = on_grid(col, row);
        k = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              res.nb[k] = cell_at(col + dc, row + dr);
              k++;
            end
          end
        end
      end
      CMD_WRITE_IDX: begin
        res.in_range = store_cell(col, row, it.new_type);
      end
      CMD_WRITE_POS: begin
        res.in_range = store_cell(px_to_cell(px, blk_w_q), px_to_cell(py, blk_h_q),
                                  it.new_type);
      end
      CMD_FILL: begin
        ncol = cols_active();
        nrow = rows_active();
        c1 = px_to_cell(px, blk_w_q);
        r1 = px_to_cell(py, blk_h_q);
        c2 = px_to_cell(px + int'(it.size_x), blk_w_q);
        r2 = px_to_cell(py + int'(it.size_y), blk_h_q);
        any = 1'b0;
        if (ncol > 0 && nrow > 0 && c2 >= 0 && r2 >= 0 && c1 < ncol && r1 < nrow) begin
          // Clip the inclusive rectangle to the grid.
          c1 = (c1 < 0) ? 0 : c1;
          r1 = (r1 < 0) ? 0 : r1;
          c2 = (c2 > ncol - 1) ? ncol - 1 : c2;
          r2 = (r2 > nrow - 1) ? nrow - 1 : r2;
          for (int c = c1; c <= c2; c++)
            for (int r = r1; r <= r2; r++)
              if (store_cell(c, r, it.new_type))
                any = 1'b1;
        end
        res.in_range = any;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch in result %0d, %s: expected %0d, got %0d",
               results_checked, field, want, got);
  endfunction

  // Result side: random stalls as the current phase asks.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    tile_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_USED_W-1:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result beat with no command waiting: %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.cell_type !== want.cell_type)
          note_mismatch("cell_type", want.cell_type, got.cell_type);
        if (got.in_range !== want.in_range)
          note_mismatch("in_range", want.in_range, got.in_range);
        for (int k = 0; k < 8; k++)
          if (got.nb[k] !== want.nb[k])
            note_mismatch(nb_names[k], want.nb[k], got.nb[k]);
      end
      results_checked++;
    end
  end

  // Stop the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one command beat, with a random gap before it, and predict its result.
  task automatic send_tile_cmd(input logic [CMD_W-1:0] cmd, input tile_cmd_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W - $bits(tile_cmd_t)){1'b0}}, it};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results = {pending_results, predict_tile_result(cmd, it)};
    items_sent++;
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input int col, row,
                       input logic [TYPE_W-1:0] kind, input int px, py, sx, sy);
    tile_cmd_t it;
    it.cell_column = 16'(col);
    it.cell_row    = 16'(row);
    it.new_type    = kind;
    it.pos_x       = 16'(px);
    it.pos_y       = 16'(py);
    it.size_x      = 15'(sx);
    it.size_y      = 15'(sy);
    send_tile_cmd(cmd, it);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_COLUMNS: grid_cols_q = val[GRID_W-1:0];
      CFG_GRID_ROWS:    grid_rows_q = val[GRID_W-1:0];
      CFG_BLOCK_WIDTH:  blk_w_q = val;
      CFG_BLOCK_HEIGHT: blk_h_q = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] cols, rows, bw, bh);
    settle();
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_BLOCK_WIDTH, bw);
    write_reg(CFG_BLOCK_HEIGHT, bh);
    settings_count++;
  endtask

  // Reads, indexed writes and neighbour reads at the grid edges, reset values.
  task automatic test_cell_access();
    issue(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ, 63, 63, 0, 0, 0, 0, 0);
    issue(CMD_READ, 64, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ, -1, 5, 0, 0, 0, 0, 0);
    issue(CMD_READ, -32768, 32767, 0, 0, 0, 0, 0);
    issue(CMD_WRITE_IDX, 0, 0, 4'd15, 0, 0, 0, 0);
    issue(CMD_WRITE_IDX, 63, 63, 4'd9, 0, 0, 0, 0);
    issue(CMD_WRITE_IDX, 64, 63, 4'd1, 0, 0, 0, 0);
    issue(CMD_WRITE_IDX, 32767, -1, 4'd1, 0, 0, 0, 0);
    issue(CMD_NEIGH, 0, 0, 0, 0, 0, 0, 0);
    issue(CMD_NEIGH, 63, 63, 0, 0, 0, 0, 0);
    issue(CMD_NEIGH, -1, -1, 0, 0, 0, 0, 0);
    issue(CMD_NEIGH, 64, 64, 0, 0, 0, 0, 0);
  endtask

  // Position writes and fills: truncation of small negative pixels, clipping.
  task automatic test_pixel_writes();
    issue(CMD_WRITE_POS, 0, 0, 4'd3, -15, -15, 0, 0);
    issue(CMD_WRITE_POS, 0, 0, 4'd0, 1023, 1023, 0, 0);
    issue(CMD_WRITE_POS, 0, 0, 4'd5, 1024, 0, 0, 0);
    issue(CMD_WRITE_POS, 0, 0, 4'd5, -16, 0, 0, 0);
    issue(CMD_WRITE_POS, 0, 0, 4'd7, 32767, -32768, 0, 0);
    issue(CMD_FILL, 0, 0, 4'd8, -20, -20, 40, 40);
    issue(CMD_FILL, 0, 0, 4'd6, 32, 32, 0, 0);
    issue(CMD_FILL, 0, 0, 4'd1, 1100, 0, 10, 10);
    issue(CMD_FILL, 0, 0, 4'd4, -32768, -32768, 32767, 32767);
    issue(CMD_NEIGH, 1, 1, 0, 0, 0, 0, 0);
  endtask

  // Unused command codes change nothing and return an all-zero result.
  task automatic test_unused_commands();
    for (int c = CMD_FILL + 1; c < (1 << CMD_W); c++)
      issue(CMD_W'(c), 3, 3, 4'd9, 48, 48, 100, 100);
  endtask

  // Random commands, mostly aimed at and around the grid, some pure noise.
  task automatic test_random_traffic(input int count, input logic [7:0] cols, rows, bw, bh,
                                     input int send_pct, recv_pct);
    tile_cmd_t it;
    logic [127:0] noise;
    logic [CMD_W-1:0] cmd;
    int ncol, nrow, wpx, hpx, pick;
    configure(cols, rows, bw, bh);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    ncol = cols_active();
    nrow = rows_active();
    wpx  = (blk_w_q == 0) ? 1 : int'(blk_w_q);
    hpx  = (blk_h_q == 0) ? 1 : int'(blk_h_q);
    repeat (count) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      it    = noise[$bits(tile_cmd_t)-1:0];
      pick  = $urandom_range(99);
      if (pick < 5) begin
        cmd = CMD_W'(CMD_FILL + 1 + $urandom_range(2));
      end else if (pick < 15) begin
        cmd = CMD_W'($urandom_range((1 << CMD_W) - 1));
      end else begin
        cmd = CMD_W'($urandom_range(CMD_FILL));
        it.cell_column = 16'(int'($urandom_range(ncol + 1)) - 1);
        it.cell_row    = 16'(int'($urandom_range(nrow + 1)) - 1);
        it.pos_x       = 16'(int'($urandom_range((ncol + 1) * wpx)) - wpx);
        it.pos_y       = 16'(int'($urandom_range((nrow + 1) * hpx)) - hpx);
        // Fills mostly cover a few cells; now and then the whole grid.
        if ($urandom_range(99) == 0) begin
          it.size_x = 15'((ncol + 1) * wpx);
          it.size_y = 15'((nrow + 1) * hpx);
        end else begin
          it.size_x = 15'($urandom_range(3 * wpx));
          it.size_y = 15'($urandom_range(3 * hpx));
        end
      end
      send_tile_cmd(cmd, it);
    end
  endtask

  initial begin
    foreach (tile_model[c, r])
      tile_model[c][r] = TYPE_SOLID;
    grid_cols_q = GRID_COLUMNS_RST;
    grid_rows_q = GRID_ROWS_RST;
    blk_w_q     = BLOCK_WIDTH_RST;
    blk_h_q     = BLOCK_HEIGHT_RST;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_cell_access();
    test_pixel_writes();
    test_unused_commands();

    test_random_traffic(300, 8'd64, 8'd64, 8'd16, 8'd16, 0, 0);
    test_random_traffic(200, 8'd1, 8'd1, 8'd1, 8'd1, 83, 0);
    test_random_traffic(200, 8'hFF, 8'hFF, 8'd255, 8'd255, 0, 83);
    test_random_traffic(150, 8'd0, 8'd0, 8'd0, 8'd0, 32, 32);
    test_random_traffic(250, 8'd37, 8'd5, 8'd3, 8'd200, 0, 0);
    test_random_traffic(250, 8'd64, 8'd64, 8'd1, 8'd1, 83, 0);
    test_random_traffic(250, 8'd13, 8'd64, 8'd7, 8'd9, 0, 83);
    test_random_traffic(200, 8'd64, 8'd1, 8'd255, 8'd0, 32, 32);

    settle();
    $display("Covered %0d commands (directed edges, then random) over %0d register settings.",
             items_sent, settings_count);
    $display("Checked %0d result beats, %0d field mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
